// File: rtl/core/ksm_pkg.sv
// ----------------------------------------------------------------------------
// ksm_pkg
// Shared types, constants and the microcode table of the kill switch monitor.
// ----------------------------------------------------------------------------
package ksm_pkg;

   localparam int MAX_SWITCHES_DEF = 8;

   localparam int OP_W       = 1;
   localparam int INDEX_W    = 3;
   localparam int TIMEOUT_W  = 16;
   localparam int COUNT_W    = 4;
   localparam int STAMP_W    = 32;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd1000;
   localparam logic [COUNT_W-1:0]   COUNT_RST   = 4'd8;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_TIMEOUT = 2'd0,
      CSR_ACTIVE  = 2'd1,
      CSR_COUNT   = 2'd2
   } csr_index_type;

   typedef enum logic [OP_W-1:0] {
      OP_TICK   = 1'b0,
      OP_UPDATE = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ACT_WAIT     = 3'd0,
      ACT_NONE     = 3'd1,
      ACT_TICK     = 3'd2,
      ACT_SCAN     = 3'd3,
      ACT_EVAL     = 3'd4,
      ACT_UPDATE   = 3'd5,
      ACT_EMIT     = 3'd6
   } action_type;

   typedef enum logic [2:0] {
      JC_NEVER     = 3'd0,
      JC_ALWAYS    = 3'd1,
      JC_NO_REQ    = 3'd2,
      JC_UPDATE    = 3'd3,
      JC_INACTIVE  = 3'd4,
      JC_SCAN_MORE = 3'd5,
      JC_OUT_BUSY  = 3'd6
   } jump_cond_type;

   typedef logic [2:0] step_type;

   localparam step_type STEP_WAIT     = 3'd0;
   localparam step_type STEP_DISPATCH = 3'd1;
   localparam step_type STEP_TICK     = 3'd2;
   localparam step_type STEP_SCAN     = 3'd3;
   localparam step_type STEP_EVAL     = 3'd4;
   localparam step_type STEP_UPDATE   = 3'd5;
   localparam step_type STEP_EMIT     = 3'd6;

   // One control word per step; 'last' returns to the wait step when no jump
   typedef struct packed {
      action_type    action;
      jump_cond_type cond;
      step_type      target;
      logic          last;
   } ctrl_word_type;

   typedef struct packed {
      logic req_valid;
      logic is_update;
      logic active;
      logic scan_more;
      logic out_busy;
   } dp_status_type;

   function automatic ctrl_word_type ucode_rom(step_type step);
      ctrl_word_type word;
      case (step)
         STEP_WAIT:     word = '{ACT_WAIT,   JC_NO_REQ,    STEP_WAIT,   1'b0};
         STEP_DISPATCH: word = '{ACT_NONE,   JC_UPDATE,    STEP_UPDATE, 1'b0};
         STEP_TICK:     word = '{ACT_TICK,   JC_INACTIVE,  STEP_EMIT,   1'b0};
         STEP_SCAN:     word = '{ACT_SCAN,   JC_SCAN_MORE, STEP_SCAN,   1'b0};
         STEP_EVAL:     word = '{ACT_EVAL,   JC_ALWAYS,    STEP_EMIT,   1'b0};
         STEP_UPDATE:   word = '{ACT_UPDATE, JC_NEVER,     STEP_EMIT,   1'b0};
         STEP_EMIT:     word = '{ACT_EMIT,   JC_OUT_BUSY,  STEP_EMIT,   1'b1};
         default:       word = '{ACT_NONE,   JC_ALWAYS,    STEP_WAIT,   1'b0};
      endcase
      return word;
   endfunction

endpackage

// File: rtl/core/ksm_req_if.sv
// ----------------------------------------------------------------------------
// ksm_req_if
// Request channel: tick or switch update items.
// ----------------------------------------------------------------------------
interface ksm_req_if;
   logic                           valid;
   logic                           ready;
   logic [ksm_pkg::OP_W-1:0]       operation;
   logic [ksm_pkg::INDEX_W-1:0]    switch_index;
   logic                           assert_kill;
   logic                           require_updates;

   modport source (output valid, operation, switch_index, assert_kill, require_updates,
                   input ready);
   modport sink   (input valid, operation, switch_index, assert_kill, require_updates,
                   output ready);
endinterface

// File: rtl/core/ksm_rsp_if.sv
// ----------------------------------------------------------------------------
// ksm_rsp_if
// Response channel: kill state and events after each item.
// ----------------------------------------------------------------------------
interface ksm_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           kill_asserted;
   logic                           kill_event;
   logic                           enable_event;
   logic [ksm_pkg::STAMP_W-1:0]    last_change_ms;
   logic                           index_error;

   modport source (output valid, kill_asserted, kill_event, enable_event, last_change_ms,
                   index_error, input ready);
   modport sink   (input valid, kill_asserted, kill_event, enable_event, last_change_ms,
                   index_error, output ready);
endinterface

// File: rtl/core/ksm_csr_if.sv
// ----------------------------------------------------------------------------
// ksm_csr_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ksm_csr_if;
   logic                             valid;
   logic                             ready;
   logic [ksm_pkg::CSR_ADDR_W-1:0]   index;
   logic [ksm_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/ksm_sequencer.sv
// ----------------------------------------------------------------------------
// ksm_sequencer
// Step counter over the microcode table with conditional jumps.
// ----------------------------------------------------------------------------
module ksm_sequencer (
   input  logic                      clock,
   input  logic                      reset,
   input  ksm_pkg::dp_status_type    status,
   output ksm_pkg::ctrl_word_type    ctrl
);

   ksm_pkg::step_type      step_ff;
   ksm_pkg::step_type      step_in;
   ksm_pkg::ctrl_word_type word;
   logic                   take;

   assign word = ksm_pkg::ucode_rom(step_ff);
   assign ctrl = word;

   always_comb begin
      case (word.cond)
         ksm_pkg::JC_NEVER:     take = 1'b0;
         ksm_pkg::JC_ALWAYS:    take = 1'b1;
         ksm_pkg::JC_NO_REQ:    take = !status.req_valid;
         ksm_pkg::JC_UPDATE:    take = status.is_update;
         ksm_pkg::JC_INACTIVE:  take = !status.active;
         ksm_pkg::JC_SCAN_MORE: take = status.scan_more;
         ksm_pkg::JC_OUT_BUSY:  take = status.out_busy;
         default:               take = 1'b0;
      endcase
   end

   always_comb begin
      if (take) begin
         step_in = word.target;
      end else if (word.last) begin
         step_in = ksm_pkg::STEP_WAIT;
      end else begin
         step_in = step_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ksm_pkg::STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// File: rtl/core/ksm_datapath.sv
// ----------------------------------------------------------------------------
// ksm_datapath
// Switch table, clock, kill state, configuration and response register.
// ----------------------------------------------------------------------------
module ksm_datapath #(
   parameter int MAX_SWITCHES = ksm_pkg::MAX_SWITCHES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ksm_pkg::ctrl_word_type    ctrl,
   output ksm_pkg::dp_status_type    status,
   ksm_req_if.sink                   req_ch,
   ksm_rsp_if.source                 rsp_ch,
   ksm_csr_if.sink                   csr_ch
);

   localparam int IDX_W = (MAX_SWITCHES > 1) ? $clog2(MAX_SWITCHES) : 1;

   localparam int TW = ksm_pkg::TIMEOUT_W;
   localparam int SW = ksm_pkg::STAMP_W;

   // configuration
   logic [TW-1:0]                 timeout_ff, timeout_in;
   logic                          active_ff, active_in;
   logic [ksm_pkg::COUNT_W-1:0]   count_ff, count_in;

   // switch table
   logic                          enabled_ff [MAX_SWITCHES];
   logic                          enabled_in [MAX_SWITCHES];
   logic                          asserting_ff [MAX_SWITCHES];
   logic                          asserting_in [MAX_SWITCHES];
   logic                          refresh_ff [MAX_SWITCHES];
   logic                          refresh_in [MAX_SWITCHES];
   logic [TW-1:0]                 left_ff [MAX_SWITCHES];
   logic [TW-1:0]                 left_in [MAX_SWITCHES];

   logic                          kill_ff, kill_in;
   logic [SW-1:0]                 now_ff, now_in;
   logic [SW-1:0]                 stamp_ff, stamp_in;

   // per-item working state
   logic [IDX_W-1:0]              scan_idx_ff, scan_idx_in;
   logic                          seen_ff, seen_in;
   logic                          hit_ff, hit_in;
   logic                          kev_ff, kev_in;
   logic                          eev_ff, eev_in;
   logic                          ierr_ff, ierr_in;

   // latched request
   ksm_pkg::op_type               op_ff;
   logic [ksm_pkg::INDEX_W-1:0]   idx_ff;
   logic                          asrt_ff;
   logic                          need_ff;

   // response register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_kill_ff;
   logic                          rsp_kev_ff;
   logic                          rsp_eev_ff;
   logic [SW-1:0]                 rsp_stamp_ff;
   logic                          rsp_ierr_ff;

   logic                          accept;
   logic                          out_busy;
   logic                          emit;
   logic                          csr_write;
   logic                          in_use;
   logic                          idx_ok;
   logic [IDX_W-1:0]              wsel;
   logic                          kill_eval;

   assign req_ch.ready = (ctrl.action == ksm_pkg::ACT_WAIT);
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_busy     = rsp_valid_ff && !rsp_ch.ready;
   assign emit         = (ctrl.action == ksm_pkg::ACT_EMIT) && !out_busy;
   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid;

   assign status.req_valid = req_ch.valid;
   assign status.is_update = (op_ff == ksm_pkg::OP_UPDATE);
   assign status.active    = active_ff;
   assign status.scan_more = (scan_idx_ff != IDX_W'(MAX_SWITCHES - 1));
   assign status.out_busy  = out_busy;

   assign in_use    = (32'(scan_idx_ff) < 32'(count_ff));
   assign idx_ok    = (32'(idx_ff) < 32'(count_ff)) && (32'(idx_ff) < MAX_SWITCHES);
   assign wsel      = IDX_W'(idx_ff);
   assign kill_eval = hit_ff || !seen_ff;

   always_comb begin
      timeout_in   = timeout_ff;
      active_in    = active_ff;
      count_in     = count_ff;
      enabled_in   = enabled_ff;
      asserting_in = asserting_ff;
      refresh_in   = refresh_ff;
      left_in      = left_ff;
      kill_in      = kill_ff;
      now_in       = now_ff;
      stamp_in     = stamp_ff;
      scan_idx_in  = scan_idx_ff;
      seen_in      = seen_ff;
      hit_in       = hit_ff;
      kev_in       = kev_ff;
      eev_in       = eev_ff;
      ierr_in      = ierr_ff;

      case (ctrl.action)
         ksm_pkg::ACT_WAIT: begin
            if (accept) begin
               kev_in  = 1'b0;
               eev_in  = 1'b0;
               ierr_in = 1'b0;
            end
         end
         ksm_pkg::ACT_TICK: begin
            now_in = now_ff + 32'd1;
            for (int i = 0; i < MAX_SWITCHES; i++) begin
               if (left_ff[i] != '0) begin
                  left_in[i] = left_ff[i] - 16'd1;
               end
            end
            scan_idx_in = '0;
            seen_in     = 1'b0;
            hit_in      = 1'b0;
         end
         ksm_pkg::ACT_SCAN: begin
            // countdowns were already advanced by this tick
            if (in_use && enabled_ff[scan_idx_ff]) begin
               seen_in = 1'b1;
               if (asserting_ff[scan_idx_ff] ||
                   (refresh_ff[scan_idx_ff] && left_ff[scan_idx_ff] == '0)) begin
                  hit_in = 1'b1;
               end
            end
            scan_idx_in = scan_idx_ff + 1'b1;
         end
         ksm_pkg::ACT_EVAL: begin
            if (kill_eval != kill_ff) begin
               kill_in  = kill_eval;
               stamp_in = now_ff;
               kev_in   = kill_eval;
               eev_in   = !kill_eval;
            end
         end
         ksm_pkg::ACT_UPDATE: begin
            if (!idx_ok) begin
               ierr_in = 1'b1;
            end else begin
               asserting_in[wsel] = asrt_ff;
               left_in[wsel]      = timeout_ff;
               refresh_in[wsel]   = need_ff;
               enabled_in[wsel]   = 1'b1;
               if (active_ff && asrt_ff) begin
                  kill_in  = 1'b1;
                  stamp_in = now_ff;
                  kev_in   = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase

      // configuration is to arrive only while no item is in flight; the datapath itself does not enforce this
      if (csr_write) begin
         case (ksm_pkg::csr_index_type'(csr_ch.index))
            ksm_pkg::CSR_TIMEOUT: timeout_in = csr_ch.data;
            ksm_pkg::CSR_ACTIVE: begin
               if (csr_ch.data[0] && !active_ff) begin
                  stamp_in = now_ff;
               end
               active_in = csr_ch.data[0];
            end
            ksm_pkg::CSR_COUNT:   count_in = csr_ch.data[ksm_pkg::COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= ksm_pkg::TIMEOUT_RST;
         active_ff    <= 1'b0;
         count_ff     <= ksm_pkg::COUNT_RST;
         for (int i = 0; i < MAX_SWITCHES; i++) begin
            enabled_ff[i]   <= 1'b0;
            asserting_ff[i] <= 1'b0;
            refresh_ff[i]   <= 1'b0;
            left_ff[i]      <= '0;
         end
         kill_ff      <= 1'b1;
         now_ff       <= '0;
         stamp_ff     <= '0;
         scan_idx_ff  <= '0;
         seen_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         kev_ff       <= 1'b0;
         eev_ff       <= 1'b0;
         ierr_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         timeout_ff   <= timeout_in;
         active_ff    <= active_in;
         count_ff     <= count_in;
         enabled_ff   <= enabled_in;
         asserting_ff <= asserting_in;
         refresh_ff   <= refresh_in;
         left_ff      <= left_in;
         kill_ff      <= kill_in;
         now_ff       <= now_in;
         stamp_ff     <= stamp_in;
         scan_idx_ff  <= scan_idx_in;
         seen_ff      <= seen_in;
         hit_ff       <= hit_in;
         kev_ff       <= kev_in;
         eev_ff       <= eev_in;
         ierr_ff      <= ierr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= ksm_pkg::op_type'(req_ch.operation);
         idx_ff  <= req_ch.switch_index;
         asrt_ff <= req_ch.assert_kill;
         need_ff <= req_ch.require_updates;
      end
      if (emit) begin
         rsp_kill_ff  <= kill_ff;
         rsp_kev_ff   <= kev_ff;
         rsp_eev_ff   <= eev_ff;
         rsp_stamp_ff <= stamp_ff;
         rsp_ierr_ff  <= ierr_ff;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.kill_asserted  = rsp_kill_ff;
   assign rsp_ch.kill_event     = rsp_kev_ff;
   assign rsp_ch.enable_event   = rsp_eev_ff;
   assign rsp_ch.last_change_ms = rsp_stamp_ff;
   assign rsp_ch.index_error    = rsp_ierr_ff;

endmodule

// File: rtl/core/kill_switch_safety_monitor.sv
// ----------------------------------------------------------------------------
// kill_switch_safety_monitor
// Kill switch table with millisecond timeouts and aggregate kill decision.
// ----------------------------------------------------------------------------
// An item on req_ch is either a one millisecond tick or a switch update. An
// update writes one switch (asserting, needs-refresh, enabled) and reloads its
// countdown from timeout_ms; while the monitor is active an asserting update
// forces kill at once. A tick advances the millisecond clock, counts every
// countdown down and, while active, rescans the switches in use: kill
// holds if any enabled switch asserts or needs refresh and has expired,
// or if none is enabled. Each item returns exactly one response on rsp_ch.
// An item is accepted in the wait step. An update then passes the dispatch,
// update and emit steps, and a tick while the monitor is inactive the
// dispatch, tick and emit steps; an active tick passes dispatch, tick, the
// scan loop of the microcoded sequencer, which reads one switch per cycle
// over all MAX_SWITCHES entries, eval and emit. One item is
// in flight at a time; a new item is taken while the previous response still
// waits in the output register, and the sequencer holds at its last step
// until that register frees. Write csr_ch only while no item is in flight;
// writes are always taken at once.
// ----------------------------------------------------------------------------
module kill_switch_safety_monitor #(
   parameter int MAX_SWITCHES = ksm_pkg::MAX_SWITCHES_DEF
) (
   input  logic          clock,
   input  logic          reset,
   ksm_req_if.sink       req_ch,
   ksm_rsp_if.source     rsp_ch,
   ksm_csr_if.sink       csr_ch
);

   ksm_pkg::ctrl_word_type ctrl;
   ksm_pkg::dp_status_type status;

   // step counter and microcode table
   ksm_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // switch table, clock, kill state and output register
   ksm_datapath #(
      .MAX_SWITCHES (MAX_SWITCHES)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .status (status),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

endmodule

// File: rtl/core/ksm_checker.sv
// ----------------------------------------------------------------------------
// ksm_checker
// Port-level checks of the kill switch monitor, bound to the top level.
// ----------------------------------------------------------------------------
module ksm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          kill_asserted,
   input logic                          kill_event,
   input logic                          enable_event,
   input logic [ksm_pkg::STAMP_W-1:0]   last_change_ms,
   input logic                          index_error
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(kill_asserted) &&
         $stable(kill_event) && $stable(enable_event) && $stable(last_change_ms) &&
         $stable(index_error))
      else $error("stalled response changed");

   a_event_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(kill_event && enable_event))
      else $error("kill and enable event together");

   a_ierr_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && index_error |-> !kill_event && !enable_event)
      else $error("event on a rejected update");

   a_event_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!kill_event || kill_asserted) && (!enable_event || !kill_asserted))
      else $error("event disagrees with kill state");

endmodule

bind kill_switch_safety_monitor ksm_checker u_ksm_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .kill_asserted  (rsp_ch.kill_asserted),
   .kill_event     (rsp_ch.kill_event),
   .enable_event   (rsp_ch.enable_event),
   .last_change_ms (rsp_ch.last_change_ms),
   .index_error    (rsp_ch.index_error)
);
